// ===== hw/rtl/sfae_pkg.sv =====
// Shared types and constants for the smoothstep fade alpha engine.
// No dependencies; every rtl file of the block refers to it by scoped names.
package sfae_pkg;

   // command codes carried in the request tuser
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_RESET = 2'd2;

   typedef logic [1:0] cmd_type;

   // fixed field widths
   localparam int unsigned NOW_W   = 32;
   localparam int unsigned DUR_W   = 16;
   localparam int unsigned T_W     = 16;   // easing position, unsigned Q0.16
   localparam int unsigned RSP_W   = 16;   // alpha, active, updated, zero pad

   // serial multiplier operand widths
   localparam int unsigned MCAND_W = 48;
   localparam int unsigned MUL_W   = 18;
   localparam int unsigned PROD_W  = MCAND_W + MUL_W;

   // 3.0 in Q2.16, the constant term of 3 - 2t
   localparam logic [MUL_W-1:0] THREE_Q16 = 18'h30000;

endpackage

// ===== hw/rtl/sfae_div.sv =====
// Bit-serial restoring divider: floor(dividend * 2^16 / divisor), one quotient
// bit per cycle. Requires dividend < divisor. Depends on sfae_pkg.
module sfae_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [sfae_pkg::DUR_W-1:0]  dividend,
   input  logic [sfae_pkg::DUR_W-1:0]  divisor,
   output logic                        done,
   output logic [sfae_pkg::T_W-1:0]    quotient
);

   localparam int unsigned CNT_W = $clog2(sfae_pkg::T_W);

   logic [sfae_pkg::DUR_W-1:0] rem_ff;
   logic [sfae_pkg::DUR_W-1:0] dsr_ff;
   logic [sfae_pkg::T_W-1:0]   quo_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;

   logic [sfae_pkg::DUR_W:0]   rem2;
   logic [sfae_pkg::DUR_W:0]   diff;
   logic                       fits;

   // one restoring step: double the remainder and try the divisor
   always_comb begin
      rem2 = {rem_ff, 1'b0};
      diff = rem2 - {1'b0, dsr_ff};
      fits = (rem2 >= {1'b0, dsr_ff});
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(sfae_pkg::T_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (go) begin
         rem_ff <= dividend;
         dsr_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[sfae_pkg::DUR_W-1:0] : rem2[sfae_pkg::DUR_W-1:0];
         quo_ff <= {quo_ff[sfae_pkg::T_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/sfae_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// The product stays in the accumulator until the next start. Depends on sfae_pkg.
module sfae_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [sfae_pkg::MCAND_W-1:0]  mcand,
   input  logic [sfae_pkg::MUL_W-1:0]    mplier,
   output logic                          done,
   output logic [sfae_pkg::PROD_W-1:0]   product
);

   localparam int unsigned CNT_W = $clog2(sfae_pkg::MUL_W);

   logic [sfae_pkg::MCAND_W-1:0] mc_ff;
   logic [sfae_pkg::MCAND_W-1:0] hi_ff;
   logic [sfae_pkg::MUL_W-1:0]   lo_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic                         busy_ff;
   logic                         done_ff;

   logic [sfae_pkg::MCAND_W:0]   sum;

   // add the multiplicand when the current multiplier bit is set
   always_comb begin
      sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mc_ff} : '0);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(sfae_pkg::MUL_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // accumulator shifts right, product bits enter the multiplier register
   always_ff @(posedge clock) begin
      if (go) begin
         mc_ff <= mcand;
         hi_ff <= '0;
         lo_ff <= mplier;
      end else if (busy_ff) begin
         hi_ff <= sum[sfae_pkg::MCAND_W:1];
         lo_ff <= {sum[0], lo_ff[sfae_pkg::MUL_W-1:1]};
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

// ===== hw/rtl/smoothstep_fade_alpha_engine_unit.sv =====
// Smoothstep fade alpha engine, top level. Uses sfae_pkg, sfae_div and sfae_mul.
// Each request carries a command in tuser and a millisecond time in tdata and
// gives one response. Start, reset, an idle tick, an unused command and the
// completing tick go from idle to the finish state, which loads the response
// register and returns to idle, so the next request can be taken in the same
// cycle as the response is raised. A tick inside a fade runs a bit-serial divide
// for t = elapsed/duration in Q0.16, then three passes of one bit-serial 18-step
// multiplier for t*t, t*t*(3-2t) and the scale by ALPHA_MAX; then the finish
// state loads the output register in the same way. The shared multiplier takes
// most of the time of such a tick. A response held by rsp_tready stalls the
// block until it is taken. One request is worked on at a time; a new request is
// taken while the previous response still waits in the output register. The
// user must write the duration register through the csr channel only while the
// block is idle; the block does not enforce this, and the channel is always ready.
module smoothstep_fade_alpha_engine_unit #(
   parameter int unsigned ALPHA_MAX       = 255,
   parameter int unsigned ALPHA_MIN       = 0,
   parameter int unsigned DEFAULT_FADE_MS = 200,
   parameter int unsigned TIME_BITS       = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: tdata = now_ms[31:0]; tuser = command[1:0]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sfae_pkg::NOW_W-1:0]       req_tdata,
   input  logic [1:0]                       req_tuser,
   // response: tdata = alpha[7:0], active[8], updated[9], zero[15:10]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sfae_pkg::RSP_W-1:0]       rsp_tdata,
   // fade duration write
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sfae_pkg::DUR_W-1:0]       csr_data
);

   localparam int unsigned LVL_MAX = (ALPHA_MAX > ALPHA_MIN) ? ALPHA_MAX : ALPHA_MIN;
   localparam int unsigned LW      = $clog2(LVL_MAX + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_MUL_TT = 3'd2;
   localparam logic [2:0] ST_MUL_Q  = 3'd3;
   localparam logic [2:0] ST_MUL_A  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [TIME_BITS-1:0]           start_ff, start_in;
   logic [LW-1:0]                  alpha_ff, alpha_in;
   logic                           upd_ff, upd_in;
   logic [sfae_pkg::T_W-1:0]       t_ff, t_in;
   logic [sfae_pkg::DUR_W-1:0]     dur_cfg_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sfae_pkg::RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                           req_xfer;
   sfae_pkg::cmd_type              cmd;
   logic [63:0]                    now_full;
   logic [TIME_BITS-1:0]           now_t;
   logic [TIME_BITS-1:0]           elapsed;
   logic [63:0]                    elapsed_full;
   logic [sfae_pkg::DUR_W-1:0]     dur;
   logic                           done_fade;

   logic                           div_go, div_done;
   logic [sfae_pkg::T_W-1:0]       div_quo;
   logic                           mul_go, mul_done;
   logic [sfae_pkg::MCAND_W-1:0]   mul_mcand;
   logic [sfae_pkg::MUL_W-1:0]     mul_mplier;
   logic [sfae_pkg::PROD_W-1:0]    mul_prod;
   logic [16:0]                    alpha_ext;
   logic [7:0]                     alpha_sat;

   assign req_xfer  = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign cmd        = req_tuser;

   // elapsed time and completion check
   always_comb begin
      now_full     = 64'(req_tdata);
      now_t        = now_full[TIME_BITS-1:0];
      elapsed      = now_t - start_ff;
      elapsed_full = 64'(elapsed);
      dur          = (dur_cfg_ff != '0) ? dur_cfg_ff : sfae_pkg::DUR_W'(DEFAULT_FADE_MS);
      done_fade    = (|elapsed_full[63:16]) || (elapsed_full[15:0] >= dur);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      alpha_in     = alpha_ff;
      upd_in       = upd_ff;
      t_in         = t_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_go       = 1'b0;
      mul_go       = 1'b0;
      mul_mcand    = sfae_pkg::MCAND_W'(div_quo);
      mul_mplier   = sfae_pkg::MUL_W'(div_quo);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_FINISH;
               upd_in   = 1'b0;
               case (cmd)
                  sfae_pkg::CMD_START: begin
                     start_in = now_t;
                     alpha_in = LW'(ALPHA_MIN);
                  end
                  sfae_pkg::CMD_RESET: begin
                     start_in = '0;
                     alpha_in = LW'(ALPHA_MAX);
                  end
                  sfae_pkg::CMD_TICK: begin
                     if (start_ff != '0) begin
                        upd_in = 1'b1;
                        if (done_fade) begin
                           start_in = '0;
                           alpha_in = LW'(ALPHA_MAX);
                        end else begin
                           div_go   = 1'b1;
                           state_in = ST_DIV;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               t_in     = div_quo;
               mul_go   = 1'b1;
               state_in = ST_MUL_TT;
            end
         end
         ST_MUL_TT: begin
            mul_mcand  = sfae_pkg::MCAND_W'(mul_prod[31:0]);
            mul_mplier = sfae_pkg::THREE_Q16 - {1'b0, t_ff, 1'b0};
            if (mul_done) begin
               mul_go   = 1'b1;
               state_in = ST_MUL_Q;
            end
         end
         ST_MUL_Q: begin
            mul_mcand  = mul_prod[sfae_pkg::MCAND_W-1:0];
            mul_mplier = sfae_pkg::MUL_W'(ALPHA_MAX);
            if (mul_done) begin
               mul_go   = 1'b1;
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            if (mul_done) begin
               alpha_in = mul_prod[sfae_pkg::MCAND_W +: LW];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, upd_ff, (start_ff != '0), alpha_sat};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // alpha output saturates at 255
   always_comb begin
      alpha_ext = 17'(alpha_ff);
      alpha_sat = (alpha_ext > 17'd255) ? 8'hFF : alpha_ext[7:0];
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         alpha_ff     <= LW'(ALPHA_MAX);
         dur_cfg_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         alpha_ff     <= alpha_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            dur_cfg_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      upd_ff      <= upd_in;
      t_ff        <= t_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // easing position t = elapsed / duration in Q0.16
   sfae_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (elapsed_full[15:0]),
      .divisor  (dur),
      .done     (div_done),
      .quotient (div_quo)
   );

   // shared multiplier for t*t, t*t*(3-2t) and the alpha scale
   sfae_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .go      (mul_go),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .done    (mul_done),
      .product (mul_prod)
   );

endmodule
